FILE: hdl/ats_pkg.sv
// Shared types, codes and character classes of the assembler token scanner.
package ats_pkg;

   localparam int TokSlots = 3;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_NUMBER = 3'd1;
   localparam logic [2:0] MODE_IDENT  = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_ESCAPE = 3'd4;
   localparam logic [2:0] MODE_DOLLAR = 3'd5;

   localparam logic [2:0] KIND_INT     = 3'd0;
   localparam logic [2:0] KIND_FLOAT   = 3'd1;
   localparam logic [2:0] KIND_IDENT   = 3'd2;
   localparam logic [2:0] KIND_STRING  = 3'd3;
   localparam logic [2:0] KIND_COLON   = 3'd4;
   localparam logic [2:0] KIND_NEWLINE = 3'd5;
   localparam logic [2:0] KIND_END     = 3'd6;

   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_UPPER_X   = 8'h58;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  dollar;
      logic        unterm;
   } token_type;

   typedef struct packed {
      logic [1:0]                    count;
      token_type [TokSlots-1:0]      tokens;
   } batch_type;

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic number_cont(logic [7:0] c);
      return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]}) ||
             c == CH_LOWER_X || c == CH_UPPER_X || c == CH_DOT;
   endfunction

   function automatic logic ident_cont(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_DOT || c == CH_COMMA;
   endfunction

   function automatic logic [15:0] sat_inc(logic [15:0] v, logic [15:0] cap);
      return (v >= cap) ? cap : v + 16'd1;
   endfunction

   function automatic token_type make_tok(logic [2:0] kind, logic [15:0] start,
                                          logic [15:0] length, logic [7:0] dollar,
                                          logic unterm);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.dollar = dollar;
      t.unterm = unterm;
      return t;
   endfunction

endpackage

FILE: hdl/ats_scan.sv
// Input register, scan state and the per-byte token logic.
module ats_scan #(
   parameter logic [15:0] POS_CAP = 16'hFFFF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_char,
   input  logic              in_last,
   input  logic              batch_ready,
   output logic              batch_load,
   output ats_pkg::batch_type batch
);
   import ats_pkg::*;

   logic        hold_ff, hold_in;
   logic [7:0]  char_ff;
   logic        last_ff;

   logic [2:0]  mode_ff, mode_in;
   logic        saw_ff, saw_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;

   logic        advance;
   logic        consumed;
   logic [15:0] len_p1;
   logic [15:0] pos_p1;
   logic [3:0]  slot_v;
   token_type   slot_t [4];
   logic [2:0]  cnt;
   batch_type   batch_c;

   assign advance    = hold_ff && batch_ready;
   assign in_ready   = !hold_ff || batch_ready;
   assign batch_load = advance;
   assign hold_in    = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : hold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      if (in_valid && in_ready) begin
         char_ff <= in_char;
         last_ff <= in_last;
      end
   end

   always_comb begin
      len_p1   = sat_inc(len_ff, POS_CAP);
      pos_p1   = sat_inc(pos_ff, POS_CAP);
      consumed = 1'b0;
      mode_in  = mode_ff;
      saw_in   = saw_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_p1;
      slot_v   = '0;
      for (int i = 0; i < 4; i++) begin
         slot_t[i] = '0;
      end

      // Tokens closed by the current mode come first.
      case (mode_ff)
         MODE_NUMBER: begin
            if (number_cont(char_ff)) begin
               len_in   = len_p1;
               consumed = 1'b1;
               if (char_ff == CH_DOT) begin
                  saw_in = 1'b1;
               end
            end else begin
               slot_v[0] = 1'b1;
               slot_t[0] = make_tok(saw_ff ? KIND_FLOAT : KIND_INT, start_ff, len_ff,
                                    8'h00, 1'b0);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (ident_cont(char_ff)) begin
               len_in   = len_p1;
               consumed = 1'b1;
            end else begin
               slot_v[0] = 1'b1;
               slot_t[0] = make_tok(KIND_IDENT, start_ff, len_ff, 8'h00, 1'b0);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            len_in   = len_p1;
            consumed = 1'b1;
            if (char_ff == CH_BACKSLASH) begin
               mode_in = MODE_ESCAPE;
            end else if (char_ff == CH_QUOTE) begin
               slot_v[0] = 1'b1;
               slot_t[0] = make_tok(KIND_STRING, start_ff, len_p1, 8'h00, 1'b0);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_ESCAPE: begin
            len_in   = len_p1;
            consumed = 1'b1;
            mode_in  = MODE_STRING;
         end
         MODE_DOLLAR: begin
            slot_v[0] = 1'b1;
            slot_t[0] = make_tok(KIND_INT, start_ff, 16'd2, char_ff, 1'b0);
            mode_in   = MODE_IDLE;
            consumed  = 1'b1;
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // A byte not taken by the open token starts whatever follows.
      if (!consumed) begin
         saw_in   = 1'b0;
         start_in = pos_ff;
         len_in   = 16'd1;
         if (is_digit(char_ff)) begin
            mode_in = MODE_NUMBER;
         end else if (is_alpha(char_ff)) begin
            mode_in = MODE_IDENT;
         end else if (char_ff == CH_QUOTE) begin
            mode_in = MODE_STRING;
         end else if (char_ff == CH_DOLLAR) begin
            mode_in = MODE_DOLLAR;
         end else if (char_ff == CH_COLON) begin
            slot_v[1] = 1'b1;
            slot_t[1] = make_tok(KIND_COLON, pos_ff, 16'd1, 8'h00, 1'b0);
         end else if (char_ff == CH_NEWLINE) begin
            slot_v[1] = 1'b1;
            slot_t[1] = make_tok(KIND_NEWLINE, pos_ff, 16'd1, 8'h00, 1'b0);
         end
      end

      // The last byte flushes the open token and appends the end token.
      if (last_ff) begin
         case (mode_in)
            MODE_NUMBER: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(saw_in ? KIND_FLOAT : KIND_INT, start_in, len_in,
                                    8'h00, 1'b0);
            end
            MODE_IDENT: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_IDENT, start_in, len_in, 8'h00, 1'b0);
            end
            MODE_STRING, MODE_ESCAPE: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_STRING, start_in, len_in, 8'h00, 1'b1);
            end
            MODE_DOLLAR: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_INT, start_in, 16'd1, 8'h00, 1'b0);
            end
            default: begin
            end
         endcase
         slot_v[3] = 1'b1;
         slot_t[3] = make_tok(KIND_END, pos_p1, 16'd1, 8'h00, 1'b0);
         mode_in   = MODE_IDLE;
         saw_in    = 1'b0;
         start_in  = '0;
         len_in    = '0;
         pos_in    = '0;
      end

      // Pack the valid slots in order; at most three are ever valid together.
      cnt     = '0;
      batch_c = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_v[i] && cnt < 3'(TokSlots)) begin
            batch_c.tokens[cnt[1:0]] = slot_t[i];
            cnt = cnt + 3'd1;
         end
      end
      batch_c.count = cnt[1:0];
   end

   assign batch = batch_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         saw_ff   <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         saw_ff   <= saw_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: hdl/ats_batch.sv
// Result register holding one byte's tokens, sending one per cycle unless stalled.
module ats_batch (
   input  logic              clock,
   input  logic              reset,
   input  logic              batch_load,
   input  ats_pkg::batch_type batch,
   output logic              batch_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ats_pkg::token_type out_tok,
   output logic              out_last
);
   import ats_pkg::*;

   token_type [TokSlots-1:0] tok_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       fire;
   logic       at_last;

   assign out_valid   = idx_ff != cnt_ff;
   assign fire        = out_valid && out_ready;
   assign at_last     = (idx_ff + 2'd1) == cnt_ff;
   assign batch_ready = !out_valid || (fire && at_last);
   assign out_tok     = tok_ff[idx_ff];
   assign out_last    = at_last;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (batch_load) begin
         cnt_in = batch.count;
         idx_in = '0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      if (batch_load) begin
         tok_ff <= batch.tokens;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("token index ran past the token count");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(idx_ff))
      else $error("stalled token moved");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      batch_load && batch.count != 2'd0 |=> out_valid && idx_ff == 2'd0)
      else $error("loaded tokens not presented");

   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      batch_load |-> !out_valid || (fire && at_last))
      else $error("tokens overwritten before delivery");

endmodule

FILE: hdl/assembler_token_scanner_unit.sv
// Assembler token scanner: one source byte per transaction, one token per output transaction.
// A byte is taken in every cycle while the result side keeps up; a byte is held in the input
// register and its tokens pass to the result register, which presents one token per cycle
// while rsp_tready is high. A byte gives zero to three tokens (the closed word or string, a
// colon or newline, and on the last byte a flush and the end token), so the sustained rate
// is one byte per cycle when each byte gives at most one token, else set by the result
// register's token rate. Positions and lengths saturate at the smaller of MAX_SOURCE_LENGTH
// and 65535; after the last byte the scanner restarts at position 0.
module assembler_token_scanner_unit #(
   parameter longint unsigned MAX_SOURCE_LENGTH = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_byte[7:0]
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_start[15:0], token_length[31:16], dollar_value[39:32]
   output logic [3:0]  rsp_tuser,   // token_kind[2:0], unterminated[3]
   output logic        rsp_tlast    // last_of_run
);
   import ats_pkg::*;

   localparam logic [15:0] POS_CAP =
      (MAX_SOURCE_LENGTH < 64'd65535) ? 16'(MAX_SOURCE_LENGTH) : 16'hFFFF;

   logic      batch_ready;
   logic      batch_load;
   batch_type batch;
   token_type out_tok;

   ats_scan #(
      .POS_CAP(POS_CAP)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_char    (req_tdata),
      .in_last    (req_tlast),
      .batch_ready(batch_ready),
      .batch_load (batch_load),
      .batch      (batch)
   );

   ats_batch u_batch (
      .clock      (clock),
      .reset      (reset),
      .batch_load (batch_load),
      .batch      (batch),
      .batch_ready(batch_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tok    (out_tok),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {out_tok.dollar, out_tok.length, out_tok.start};
   assign rsp_tuser = {out_tok.unterm, out_tok.kind};

endmodule
